>>> hw/rtl/tmcw_pkg.sv
package tmcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = ROWS * COLUMNS;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int ADDR_W     = 11;
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 8;
  localparam int CELL_W     = CH_W + COLOR_W;
  localparam int CMD_W      = 3;
  localparam int TAB_SPACES = 4;
  localparam int TAB_W      = $clog2(TAB_SPACES);

  localparam logic [ROW_W-1:0]   ROW_LIMIT   = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0]   ROW_LAST    = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]   COL_LIMIT   = COL_W'(COLUMNS);
  localparam logic [COL_W-1:0]   COL_LAST    = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0]  ROW_SPAN    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0]  ADDR_LAST   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0]  SCROLL_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [TAB_W-1:0]   TAB_REST    = TAB_W'(TAB_SPACES - 1);

  localparam logic [CH_W-1:0]    CH_BLANK     = 8'd0;
  localparam logic [CH_W-1:0]    CH_BACKSPACE = 8'd8;
  localparam logic [CH_W-1:0]    CH_TAB       = 8'd9;
  localparam logic [CH_W-1:0]    CH_NEWLINE   = 8'd10;
  localparam logic [CH_W-1:0]    CH_SPACE     = 8'd32;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h0F;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CHAR = 3'd0,
    CMD_PUT_AT   = 3'd1,
    CMD_CLEAR    = 3'd2,
    CMD_RECOLOR  = 3'd3,
    CMD_READ     = 3'd4
  } cmd_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ROW_SPAN + ADDR_W'(col);
  endfunction

  function automatic logic [CELL_W-1:0] make_cell(input logic [CH_W-1:0]    ch,
                                                  input logic [COLOR_W-1:0] color);
    return {color, ch};
  endfunction

endpackage

>>> hw/rtl/tmcw_if.sv
interface tmcw_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [tmcw_pkg::CMD_W-1:0]    command;
  logic [tmcw_pkg::CH_W-1:0]     char_code;
  logic [tmcw_pkg::COLOR_W-1:0]  cell_color;
  logic [tmcw_pkg::ROW_W-1:0]    target_row;
  logic [tmcw_pkg::COL_W-1:0]    target_column;

  modport source (output valid, command, char_code, cell_color, target_row, target_column,
                  input ready);
  modport sink (input valid, command, char_code, cell_color, target_row, target_column,
                output ready);
endinterface

interface tmcw_res_if;
  logic                          valid;
  logic                          ready;
  logic [tmcw_pkg::ROW_W-1:0]    cursor_row;
  logic [tmcw_pkg::COL_W-1:0]    cursor_column;
  logic [tmcw_pkg::ADDR_W-1:0]   cursor_position;
  logic [tmcw_pkg::CELL_W-1:0]   cell_data;

  modport source (output valid, cursor_row, cursor_column, cursor_position, cell_data,
                  input ready);
  modport sink (input valid, cursor_row, cursor_column, cursor_position, cell_data,
                output ready);
endinterface

>>> hw/rtl/tmcw_screen.sv
module tmcw_screen (
  input  logic                          clk_i,
  input  tmcw_pkg::mem_req_t            req_i,
  output logic [tmcw_pkg::CELL_W-1:0]   rd_data_o
);

  logic [tmcw_pkg::CELL_W-1:0] mem [tmcw_pkg::CELLS];
  logic [tmcw_pkg::CELL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/text_mode_console_writer.sv
// Steps: put at position, read cell and newline without scroll go straight to the result.
// Ordinary character and backspace write one cell, tab four spaces; a scroll moves 1920 cells
// up a row and blanks 80. Clear walks 2000 cells; recolor reads and writes each cell.
// One item at a time through the one-read, one-write screen memory; not ready while busy.
// Reset: a clearing pass over each cell fills the screen with character 0 in color 0x0F;
// no item is accepted meanwhile. Cursor goes to (0,0), text color to 0x0F.
module text_mode_console_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tmcw_cmd_if.sink                      cmd_i,
  tmcw_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [tmcw_pkg::COLOR_W-1:0]  cfg_wdata_i
);

  typedef enum logic [8:0] {
    ST_INIT    = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_PUT     = 9'b000000100,
    ST_SCRL_RD = 9'b000001000,
    ST_SCRL_WR = 9'b000010000,
    ST_BLANK   = 9'b000100000,
    ST_RC_RD   = 9'b001000000,
    ST_RC_WR   = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_e;

  state_e                         state_q, state_d;
  logic [tmcw_pkg::ROW_W-1:0]     row_q, row_d;
  logic [tmcw_pkg::COL_W-1:0]     col_q, col_d;
  logic [tmcw_pkg::ADDR_W-1:0]    addr_q, addr_d;
  logic [tmcw_pkg::COLOR_W-1:0]   color_q, color_d;
  logic [tmcw_pkg::CH_W-1:0]      ch_q, ch_d;
  logic [tmcw_pkg::TAB_W-1:0]     tab_q, tab_d;
  logic                           adv_q, adv_d;
  logic                           cont_q, cont_d;
  logic                           rd_sel_q, rd_sel_d;
  logic                           out_valid_q, out_valid_d;
  logic [tmcw_pkg::ROW_W-1:0]     out_row_q, out_row_d;
  logic [tmcw_pkg::COL_W-1:0]     out_col_q, out_col_d;
  logic [tmcw_pkg::ADDR_W-1:0]    out_pos_q, out_pos_d;
  logic [tmcw_pkg::CELL_W-1:0]    out_data_q, out_data_d;

  tmcw_pkg::mem_req_t             req;
  logic [tmcw_pkg::CELL_W-1:0]    rd_data;
  logic [tmcw_pkg::COL_W-1:0]     adv_col;
  logic                           wrap;
  logic                           at_bottom;
  logic                           in_range;
  logic                           more;

  tmcw_screen u_screen (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  assign adv_col   = col_q + 1'b1;
  assign wrap      = adv_col >= tmcw_pkg::COL_LIMIT;
  assign at_bottom = row_q >= tmcw_pkg::ROW_LAST;
  assign in_range  = (cmd_i.target_row < tmcw_pkg::ROW_LIMIT) &&
                     (cmd_i.target_column < tmcw_pkg::COL_LIMIT);
  assign more      = tab_q != '0;

  assign cmd_i.ready           = state_q == ST_IDLE;
  assign res_o.valid           = out_valid_q;
  assign res_o.cursor_row      = out_row_q;
  assign res_o.cursor_column   = out_col_q;
  assign res_o.cursor_position = out_pos_q;
  assign res_o.cell_data       = out_data_q;

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    addr_d      = addr_q;
    color_d     = cfg_we_i ? cfg_wdata_i : color_q;
    ch_d        = ch_q;
    tab_d       = tab_q;
    adv_d       = adv_q;
    cont_d      = cont_q;
    rd_sel_d    = rd_sel_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_pos_d   = out_pos_q;
    out_data_d  = out_data_q;
    req         = '0;

    unique case (state_q)
      ST_INIT: begin
        req.we    = 1'b1;
        req.waddr = addr_q;
        req.wdata = tmcw_pkg::make_cell(tmcw_pkg::CH_BLANK, tmcw_pkg::COLOR_RESET);
        if (addr_q == tmcw_pkg::ADDR_LAST) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (cmd_i.valid) begin
          rd_sel_d = 1'b0;
          cont_d   = 1'b0;
          tab_d    = '0;
          state_d  = ST_DONE;
          unique case (cmd_i.command)
            tmcw_pkg::CMD_PUT_CHAR: begin
              priority if (cmd_i.char_code == tmcw_pkg::CH_NEWLINE) begin
                col_d = '0;
                if (at_bottom) begin
                  row_d   = tmcw_pkg::ROW_LAST;
                  addr_d  = '0;
                  state_d = ST_SCRL_RD;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else if (cmd_i.char_code == tmcw_pkg::CH_BACKSPACE) begin
                if (col_q != '0) begin
                  col_d = col_q - 1'b1;
                end else if (row_q != '0) begin
                  col_d = tmcw_pkg::COL_LAST;
                  row_d = row_q - 1'b1;
                end
                ch_d    = tmcw_pkg::CH_BLANK;
                adv_d   = 1'b0;
                state_d = ST_PUT;
              end else if (cmd_i.char_code == tmcw_pkg::CH_TAB) begin
                ch_d    = tmcw_pkg::CH_SPACE;
                adv_d   = 1'b1;
                tab_d   = tmcw_pkg::TAB_REST;
                state_d = ST_PUT;
              end else begin
                ch_d    = cmd_i.char_code;
                adv_d   = 1'b1;
                state_d = ST_PUT;
              end
            end
            tmcw_pkg::CMD_PUT_AT: begin
              req.we    = in_range;
              req.waddr = tmcw_pkg::cell_addr(cmd_i.target_row, cmd_i.target_column);
              req.wdata = tmcw_pkg::make_cell(cmd_i.char_code, cmd_i.cell_color);
            end
            tmcw_pkg::CMD_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              addr_d  = '0;
              state_d = ST_BLANK;
            end
            tmcw_pkg::CMD_RECOLOR: begin
              addr_d  = '0;
              state_d = ST_RC_RD;
            end
            tmcw_pkg::CMD_READ: begin
              req.re   = in_range;
              req.raddr = tmcw_pkg::cell_addr(cmd_i.target_row, cmd_i.target_column);
              rd_sel_d = in_range;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_PUT: begin
        req.we    = 1'b1;
        req.waddr = tmcw_pkg::cell_addr(row_q, col_q);
        req.wdata = tmcw_pkg::make_cell(ch_q, color_q);
        if (more) begin
          tab_d = tab_q - 1'b1;
        end
        if (!adv_q) begin
          state_d = ST_DONE;
        end else if (wrap) begin
          col_d = '0;
          if (at_bottom) begin
            row_d   = tmcw_pkg::ROW_LAST;
            addr_d  = '0;
            cont_d  = more;
            state_d = ST_SCRL_RD;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = more ? ST_PUT : ST_DONE;
          end
        end else begin
          col_d   = adv_col;
          state_d = more ? ST_PUT : ST_DONE;
        end
      end

      ST_SCRL_RD: begin
        req.re    = 1'b1;
        req.raddr = addr_q + tmcw_pkg::ROW_SPAN;
        state_d   = ST_SCRL_WR;
      end

      ST_SCRL_WR: begin
        req.we    = 1'b1;
        req.waddr = addr_q;
        req.wdata = rd_data;
        addr_d    = addr_q + 1'b1;
        state_d   = (addr_q == tmcw_pkg::SCROLL_LAST) ? ST_BLANK : ST_SCRL_RD;
      end

      ST_BLANK: begin
        req.we    = 1'b1;
        req.waddr = addr_q;
        req.wdata = tmcw_pkg::make_cell(tmcw_pkg::CH_BLANK, color_q);
        if (addr_q == tmcw_pkg::ADDR_LAST) begin
          cont_d  = 1'b0;
          state_d = cont_q ? ST_PUT : ST_DONE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      ST_RC_RD: begin
        req.re    = 1'b1;
        req.raddr = addr_q;
        state_d   = ST_RC_WR;
      end

      ST_RC_WR: begin
        req.we    = 1'b1;
        req.waddr = addr_q;
        req.wdata = tmcw_pkg::make_cell(rd_data[tmcw_pkg::CH_W-1:0], color_q);
        if (addr_q == tmcw_pkg::ADDR_LAST) begin
          state_d = ST_DONE;
        end else begin
          addr_d  = addr_q + 1'b1;
          state_d = ST_RC_RD;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_row_d   = row_q;
          out_col_d   = col_q;
          out_pos_d   = tmcw_pkg::cell_addr(row_q, col_q);
          out_data_d  = rd_sel_q ? rd_data : '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      addr_q      <= '0;
      color_q     <= tmcw_pkg::COLOR_RESET;
      tab_q       <= '0;
      adv_q       <= 1'b0;
      cont_q      <= 1'b0;
      rd_sel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      addr_q      <= addr_d;
      color_q     <= color_d;
      tab_q       <= tab_d;
      adv_q       <= adv_d;
      cont_q      <= cont_d;
      rd_sel_q    <= rd_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_pos_q  <= out_pos_d;
    out_data_q <= out_data_d;
  end

endmodule

>>> bench/text_mode_console_writer_check.sv
module text_mode_console_writer_check
  import tmcw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  tmcw_cmd_if                 cmd_i,
  tmcw_res_if                 res_i,
  input  logic                cfg_we_i,
  input  logic [COLOR_W-1:0]  cfg_wdata_i,
  output int                  mismatches_o,
  output int                  outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [ADDR_W-1:0] position;
    logic [CELL_W-1:0] data;
  } cursor_report_t;

  logic [CELL_W-1:0]  screen [CELLS];
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [COLOR_W-1:0] ink;
  cursor_report_t     awaited_reports [$];
  int                 mismatches = 0;

  task automatic flag_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int cursor_cell();
    return int'(cur_row) * COLUMNS + int'(cur_col);
  endfunction

  task automatic wipe_screen();
    cur_row = '0;
    cur_col = '0;
    for (int i = 0; i < CELLS; i++) screen[i] = {ink, CH_BLANK};
  endtask

  task automatic line_feed();
    cur_col = '0;
    if (cur_row >= ROW_LAST) begin
      cur_row = ROW_LAST;
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {ink, CH_BLANK};
    end else begin
      cur_row = cur_row + 1'b1;
    end
  endtask

  task automatic type_glyph(input logic [CH_W-1:0] ch);
    screen[cursor_cell()] = {ink, ch};
    if (int'(cur_col) + 1 >= COLUMNS) begin
      line_feed();
    end else begin
      cur_col = cur_col + 1'b1;
    end
  endtask

  task automatic console_step(input logic [CMD_W-1:0] op, input logic [CH_W-1:0] ch,
                              input logic [COLOR_W-1:0] color, input logic [ROW_W-1:0] row,
                              input logic [COL_W-1:0] col, output cursor_report_t rpt);
    bit on_screen;
    int target;
    on_screen = (row < ROW_LIMIT) && (col < COL_LIMIT);
    target = int'(row) * COLUMNS + int'(col);
    rpt.data = '0;
    case (op)
      CMD_PUT_CHAR: begin
        case (ch)
          CH_NEWLINE: line_feed();
          CH_BACKSPACE: begin
            if (cur_col != '0) begin
              cur_col = cur_col - 1'b1;
            end else if (cur_row != '0) begin
              cur_col = COL_LAST;
              cur_row = cur_row - 1'b1;
            end
            screen[cursor_cell()] = {ink, CH_BLANK};
          end
          CH_TAB: repeat (TAB_SPACES) type_glyph(CH_SPACE);
          default: type_glyph(ch);
        endcase
      end
      CMD_PUT_AT: if (on_screen) screen[target] = {color, ch};
      CMD_CLEAR: wipe_screen();
      CMD_RECOLOR: for (int i = 0; i < CELLS; i++) screen[i][CELL_W-1:CH_W] = ink;
      CMD_READ: if (on_screen) rpt.data = screen[target];
      default: ;
    endcase
    rpt.row      = cur_row;
    rpt.column   = cur_col;
    rpt.position = ADDR_W'(cursor_cell());
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_report_t want;
    cursor_report_t fresh;
    if (!rst_ni) begin
      ink = COLOR_RESET;
      wipe_screen();
      awaited_reports.delete();
      outstanding_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (awaited_reports.size() == 0) begin
          flag_mismatch("result item with nothing expected");
        end else begin
          want = awaited_reports.pop_front();
          if (res_i.cursor_row !== want.row)
            flag_mismatch($sformatf("cursor_row got %0d want %0d", res_i.cursor_row, want.row));
          if (res_i.cursor_column !== want.column)
            flag_mismatch($sformatf("cursor_column got %0d want %0d",
                                    res_i.cursor_column, want.column));
          if (res_i.cursor_position !== want.position)
            flag_mismatch($sformatf("cursor_position got %0d want %0d",
                                    res_i.cursor_position, want.position));
          if (res_i.cell_data !== want.data)
            flag_mismatch($sformatf("cell_data got %h want %h", res_i.cell_data, want.data));
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        console_step(cmd_i.command, cmd_i.char_code, cmd_i.cell_color, cmd_i.target_row,
                     cmd_i.target_column, fresh);
        awaited_reports.push_back(fresh);
      end
      if (cfg_we_i) ink = cfg_wdata_i;
      outstanding_o <= awaited_reports.size();
    end
    mismatches_o <= mismatches;
  end

endmodule

>>> bench/text_mode_console_writer_test.sv
module text_mode_console_writer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tmcw_pkg::*;

  localparam longint CYCLE_LIMIT = 8_000_000;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     PHASE_ITEMS = 335;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COLOR_W-1:0] cfg_wdata_i;
  int                 fail_total;
  int                 open_total;
  int                 items_sent = 0;
  int                 results_seen = 0;
  int                 send_pct = 0;
  int                 stall_pct = 0;
  longint             cycle_count = 0;

  tmcw_cmd_if cmd_ch ();
  tmcw_res_if res_ch ();

  text_mode_console_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  text_mode_console_writer_check result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_ch),
    .res_i         (res_ch),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches_o  (fail_total),
    .outstanding_o (open_total)
  );

  always begin
    #10ns clk_i = 1'b1;
    #10ns clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (res_ch.valid && res_ch.ready) results_seen <= results_seen + 1;
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic issue(input logic [CMD_W-1:0] op, input logic [CH_W-1:0] ch,
                       input logic [COLOR_W-1:0] color, input logic [ROW_W-1:0] row,
                       input logic [COL_W-1:0] col);
    while ($urandom_range(99) < send_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.command       <= op;
    cmd_ch.char_code     <= ch;
    cmd_ch.cell_color    <= color;
    cmd_ch.target_row    <= row;
    cmd_ch.target_column <= col;
    do @(posedge clk_i); while (!cmd_ch.ready);
    items_sent++;
  endtask

  task automatic type_char(input logic [CH_W-1:0] ch);
    issue(CMD_PUT_CHAR, ch, COLOR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic place(input logic [CH_W-1:0] ch, input logic [COLOR_W-1:0] color,
                       input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    issue(CMD_PUT_AT, ch, color, row, col);
  endtask

  task automatic peek(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    issue(CMD_READ, CH_W'($urandom), COLOR_W'($urandom), row, col);
  endtask

  task automatic whole_screen(input logic [CMD_W-1:0] op);
    issue(op, CH_W'($urandom), COLOR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic odd_command();
    whole_screen(CMD_W'($urandom_range(int'(CMD_READ) + 1, (1 << CMD_W) - 1)));
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [COLOR_W-1:0] color, input int s_pct,
                              input int r_pct);
    int goal;
    int kind;
    int len;
    int pick;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= color;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    send_pct  <= s_pct;
    stall_pct <= r_pct;
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) begin
      kind = $urandom_range(99);
      row  = ROW_W'($urandom_range(ROWS - 1));
      col  = COL_W'($urandom_range(COLUMNS - 1));
      if ($urandom_range(9) == 0) begin
        row = ROW_W'($urandom);
        col = COL_W'($urandom);
      end
      if (kind < 42) begin
        len = $urandom_range(1, 12);
        repeat (len) begin
          pick = $urandom_range(99);
          if (pick < 10) type_char(CH_NEWLINE);
          else if (pick < 16) type_char(CH_TAB);
          else if (pick < 24) type_char(CH_BACKSPACE);
          else type_char(CH_W'($urandom));
        end
      end else if (kind < 60) begin
        place(CH_W'($urandom), COLOR_W'($urandom), row, col);
      end else if (kind < 78) begin
        peek(row, col);
      end else if (kind < 82) begin
        // sweep a row near the top or the bottom of the screen
        pick = $urandom_range(1) ? ROWS - 1 - $urandom_range(2) : $urandom_range(2);
        for (int c = 0; c < COLUMNS; c += $urandom_range(1, 4)) peek(ROW_W'(pick), COL_W'(c));
      end else if (kind < 84) begin
        len = $urandom_range(COLUMNS - 10, COLUMNS + 10);
        repeat (len) type_char(CH_W'($urandom_range(33, 126)));
      end else if (kind < 85) begin
        whole_screen(CMD_CLEAR);
      end else if (kind < 86) begin
        whole_screen(CMD_RECOLOR);
      end else if (kind < 88) begin
        odd_command();
      end else begin
        place(CH_W'($urandom), COLOR_W'($urandom), row, col);
        peek(row, col);
      end
    end
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.command       <= CMD_PUT_CHAR;
    cmd_ch.char_code     <= '0;
    cmd_ch.cell_color    <= '0;
    cmd_ch.target_row    <= '0;
    cmd_ch.target_column <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    peek('0, '0);
    peek(ROW_LAST, COL_LAST);
    place(8'hFF, 8'hFF, '0, '0);
    place(CH_BLANK, 8'h00, ROW_LAST, COL_LAST);
    place(8'h41, 8'h3C, '1, '0);
    place(8'h42, 8'hC3, '0, '1);
    peek(ROW_LAST, COL_LAST);
    peek('1, '1);
    peek(ROW_LIMIT, COL_LIMIT);
    type_char(8'h41);
    type_char(CH_TAB);
    type_char(CH_BACKSPACE);
    type_char(CH_NEWLINE);
    type_char(CH_BACKSPACE);
    peek('0, COL_LAST);
    whole_screen(CMD_CLEAR);
    type_char(CH_BACKSPACE);
    type_char(CH_BLANK);
    type_char(8'hFF);
    whole_screen(CMD_RECOLOR);
    for (int op = int'(CMD_READ) + 1; op < (1 << CMD_W); op++) whole_screen(CMD_W'(op));
    peek('0, '0);

    random_phase(8'h00, 0, 0);
    random_phase(8'hFF, 56, 0);
    random_phase(COLOR_W'($urandom), 0, 56);
    random_phase(COLOR_W'($urandom), 24, 24);
    random_phase(COLOR_W'($urandom), 0, 0);
    settle();

    if (fail_total == 0 && open_total == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> text_mode_console_writer.f
hw/rtl/tmcw_pkg.sv
hw/rtl/tmcw_if.sv
hw/rtl/tmcw_screen.sv
hw/rtl/text_mode_console_writer.sv
bench/text_mode_console_writer_check.sv
bench/text_mode_console_writer_test.sv
